[rtl/core/sbt_pkg.sv]
// ----------------------------------------------------------------------------
// sbt_pkg: shared types and constants for the scheduled bandwidth throttle
// Field widths, operation codes, fixed-point constants and the structs that
// pass between the top level and the rate check engine.
// ----------------------------------------------------------------------------
package sbt_pkg;

  localparam int OP_W    = 2;
  localparam int BYTES_W = 20;
  localparam int TIME_W  = 63;
  localparam int HOUR_W  = 5;
  localparam int RATE_W  = 20;
  localparam int DELAY_W = 32;
  localparam int TOTAL_W = 64;
  localparam int CPS_W   = 20;

  // Engine datapath: accumulator wide enough for bytes * 1e9.
  localparam int ACC_W = 96;
  // Multiplier shift register: widest constant multiplier (1e9).
  localparam int MPL_W = 30;
  // Divisor kbs * 1e6 * 1024.
  localparam int D_W   = 50;
  // Scaled delay: delay * 1e6.
  localparam int MS_W  = DELAY_W + 20;

  localparam logic [OP_W-1:0] OP_REPORT = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE  = 2'd1;
  localparam logic [OP_W-1:0] OP_START  = 2'd2;

  localparam logic [29:0]        NS_PER_SEC = 30'd1000000000;
  localparam logic [19:0]        NS_PER_MS  = 20'd1000000;
  localparam logic [DELAY_W-1:0] DELAY_MAX  = '1;
  localparam logic [CPS_W-1:0]   CPS_RESET  = 20'd1000;

  typedef struct packed {
    logic                go;
    logic [TOTAL_W-1:0]  bytes;
    logic [RATE_W-1:0]   kbs;
    logic [TIME_W-1:0]   elapsed;
    logic [CPS_W-1:0]    cps;
  } sbt_job_t;

  typedef struct packed {
    logic                busy;
    logic                valid;
    logic                due;
    logic [DELAY_W-1:0]  delay;
  } sbt_res_t;

  typedef struct packed {
    logic inv;
    logic cin;
  } sbt_alu_ctl_t;

endpackage

[rtl/core/sbt_req_if.sv]
// ----------------------------------------------------------------------------
// sbt_req_if: request channel of the scheduled bandwidth throttle
// Valid/ready channel carrying one operation beat.
// ----------------------------------------------------------------------------
interface sbt_req_if import sbt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [BYTES_W-1:0] byte_count;
  logic [TIME_W-1:0] now_ns;
  logic [HOUR_W-1:0] hour_slot;
  logic [RATE_W-1:0] slot_rate;

  modport source (output valid, operation, byte_count, now_ns, hour_slot, slot_rate,
                  input ready);
  modport sink (input valid, operation, byte_count, now_ns, hour_slot, slot_rate,
                output ready);
endinterface

[rtl/core/sbt_rsp_if.sv]
// ----------------------------------------------------------------------------
// sbt_rsp_if: response channel of the scheduled bandwidth throttle
// Valid/ready channel carrying one result beat per request.
// ----------------------------------------------------------------------------
interface sbt_rsp_if import sbt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [DELAY_W-1:0] delay_ms;
  logic               check_done;
  logic [TOTAL_W-1:0] grand_total;

  modport source (output valid, delay_ms, check_done, grand_total, input ready);
  modport sink (input valid, delay_ms, check_done, grand_total, output ready);
endinterface

[rtl/core/sbt_cfg_if.sv]
// ----------------------------------------------------------------------------
// sbt_cfg_if: configuration write channel
// Valid/ready channel carrying the checks-per-second register value.
// ----------------------------------------------------------------------------
interface sbt_cfg_if import sbt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CPS_W-1:0] checks_per_second;

  modport source (output valid, checks_per_second, input ready);
  modport sink (input valid, checks_per_second, output ready);
endinterface

[rtl/core/sbt_alu.sv]
// ----------------------------------------------------------------------------
// sbt_alu: shared adder/subtractor of the rate check engine
// Computes a + (b or ~b) + cin with carry out; used for multiply steps,
// compares and division steps.
// ----------------------------------------------------------------------------
module sbt_alu import sbt_pkg::*; (
  input  logic [ACC_W-1:0] a,
  input  logic [ACC_W-1:0] b,
  input  sbt_alu_ctl_t     ctl,
  output logic [ACC_W-1:0] sum,
  output logic             carry
);

  logic [ACC_W-1:0] b_eff;

  assign b_eff = ctl.inv ? ~b : b;
  assign {carry, sum} = {1'b0, a} + {1'b0, b_eff} + {{ACC_W{1'b0}}, ctl.cin};

endmodule

[rtl/core/sbt_sched.sv]
// ----------------------------------------------------------------------------
// sbt_sched: hourly rate schedule store
// One KB/s limit per slot; slots never written and out-of-range slots
// read as zero (unlimited). The read is registered on the request beat.
// ----------------------------------------------------------------------------
module sbt_sched import sbt_pkg::*; #(
  parameter int SLOTS = 24
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [HOUR_W-1:0] wr_slot,
  input  logic [RATE_W-1:0] wr_rate,
  input  logic              rd_en,
  input  logic [HOUR_W-1:0] rd_slot,
  output logic [RATE_W-1:0] rd_rate
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SEL_W = 7;

  logic [RATE_W-1:0] entry [SLOTS];
  logic [SLOTS-1:0]  valid;
  logic [SEL_W-1:0]  wr_sel;
  logic [SEL_W-1:0]  rd_sel;
  logic [IDX_W-1:0]  wr_idx;
  logic [IDX_W-1:0]  rd_idx;
  logic              wr_hit;
  logic              rd_hit;

  assign wr_sel = SEL_W'(wr_slot);
  assign rd_sel = SEL_W'(rd_slot);
  assign wr_hit = wr_sel < SEL_W'(SLOTS);
  assign rd_hit = rd_sel < SEL_W'(SLOTS);
  assign wr_idx = wr_sel[IDX_W-1:0];
  assign rd_idx = rd_sel[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en && wr_hit) begin
      valid[wr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && wr_hit) begin
      entry[wr_idx] <= wr_rate;
    end
  end

  // Hold the looked-up limit until the next request beat.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_rate <= (rd_hit && valid[rd_idx]) ? entry[rd_idx] : '0;
    end
  end

endmodule

[rtl/core/sbt_engine.sv]
// ----------------------------------------------------------------------------
// sbt_engine: iterative rate check engine
// Sequences the shared adder through the due test, shift-add multiplies and
// a restoring division that yields the number of 1 ms sleeps.
// ----------------------------------------------------------------------------
module sbt_engine import sbt_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  sbt_job_t job,
  output sbt_res_t res
);

  localparam logic [3:0] E_IDLE    = 4'd0;
  localparam logic [3:0] E_DUE_MUL = 4'd1;
  localparam logic [3:0] E_DUE_CMP = 4'd2;
  localparam logic [3:0] E_B_MUL   = 4'd3;
  localparam logic [3:0] E_K_MUL   = 4'd4;
  localparam logic [3:0] E_N_SUB   = 4'd5;
  localparam logic [3:0] E_D_MUL   = 4'd6;
  localparam logic [3:0] E_OVF     = 4'd7;
  localparam logic [3:0] E_DIV     = 4'd8;
  localparam logic [3:0] E_INC     = 4'd9;
  localparam logic [3:0] E_DONE    = 4'd10;

  localparam logic [4:0] CNT_B = 5'(MPL_W - 1);
  localparam logic [4:0] CNT_R = 5'(RATE_W - 1);
  localparam logic [4:0] CNT_Q = 5'(DELAY_W - 1);

  logic [3:0]         state;
  logic [ACC_W-1:0]   acc;
  logic [ACC_W-1:0]   mcand;
  logic [MPL_W-1:0]   mplier;
  logic [4:0]         cnt;
  logic [ACC_W-1:0]   nreg;
  logic [D_W-1:0]     dreg;
  logic [DELAY_W-1:0] quo;
  logic               due;
  logic [DELAY_W-1:0] delay;

  logic [ACC_W-1:0]   alu_a;
  logic [ACC_W-1:0]   alu_b;
  sbt_alu_ctl_t       alu_ctl;
  logic [ACC_W-1:0]   alu_sum;
  logic               alu_carry;

  logic [DELAY_W-1:0] nlow;
  logic [D_W:0]       div_a;

  assign nlow  = nreg[DELAY_W-1:0];
  assign div_a = {acc[D_W-1:0], nlow[cnt]};

  sbt_alu u_alu (
    .a     (alu_a),
    .b     (alu_b),
    .ctl   (alu_ctl),
    .sum   (alu_sum),
    .carry (alu_carry)
  );

  // Operand select: multiply steps add the shifted multiplicand when the
  // current multiplier bit is set; compares subtract and read the carry.
  always_comb begin
    alu_a   = acc;
    alu_b   = mplier[0] ? mcand : '0;
    alu_ctl = '{inv: 1'b0, cin: 1'b0};
    unique case (state)
      E_DUE_CMP: begin
        alu_a   = ACC_W'(NS_PER_SEC);
        alu_b   = acc;
        alu_ctl = '{inv: 1'b1, cin: 1'b1};
      end
      E_N_SUB: begin
        // bytes*1e9 - kbs*elapsed*1024 - 1; carry set when the difference is positive
        alu_a   = nreg;
        alu_b   = {acc[ACC_W-11:0], 10'b0};
        alu_ctl = '{inv: 1'b1, cin: 1'b0};
      end
      E_OVF: begin
        alu_a   = ACC_W'(nreg[ACC_W-1:DELAY_W]);
        alu_b   = ACC_W'(dreg);
        alu_ctl = '{inv: 1'b1, cin: 1'b1};
      end
      E_DIV: begin
        alu_a   = ACC_W'(div_a);
        alu_b   = ACC_W'(dreg);
        alu_ctl = '{inv: 1'b1, cin: 1'b1};
      end
      E_INC: begin
        alu_a   = ACC_W'(quo);
        alu_b   = '0;
        alu_ctl = '{inv: 1'b0, cin: 1'b1};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= E_IDLE;
    end else begin
      unique case (state)
        E_IDLE: begin
          if (job.go) begin
            if (job.cps == '0 || job.elapsed[TIME_W-1:30] != '0) begin
              due    <= 1'b1;
              acc    <= '0;
              mcand  <= ACC_W'(job.bytes);
              mplier <= NS_PER_SEC;
              cnt    <= CNT_B;
              state  <= E_B_MUL;
            end else begin
              // (elapsed + 1) * cps, seeded with cps
              acc    <= ACC_W'(job.cps);
              mcand  <= ACC_W'(job.elapsed);
              mplier <= MPL_W'(job.cps);
              cnt    <= CNT_R;
              state  <= E_DUE_MUL;
            end
          end
        end
        E_DUE_MUL, E_B_MUL, E_K_MUL, E_D_MUL: begin
          if (cnt != '0) begin
            acc    <= alu_sum;
            mcand  <= mcand << 1;
            mplier <= mplier >> 1;
            cnt    <= cnt - 5'd1;
          end else begin
            unique case (state)
              E_DUE_MUL: begin
                acc   <= alu_sum;
                state <= E_DUE_CMP;
              end
              E_B_MUL: begin
                nreg   <= alu_sum;
                acc    <= '0;
                mcand  <= ACC_W'(job.elapsed);
                mplier <= MPL_W'(job.kbs);
                cnt    <= CNT_R;
                state  <= E_K_MUL;
              end
              E_K_MUL: begin
                acc   <= alu_sum;
                state <= E_N_SUB;
              end
              default: begin
                dreg  <= {alu_sum[D_W-11:0], 10'b0};
                state <= E_OVF;
              end
            endcase
          end
        end
        E_DUE_CMP: begin
          if (alu_carry) begin
            due   <= 1'b0;
            delay <= '0;
            state <= E_DONE;
          end else begin
            due    <= 1'b1;
            acc    <= '0;
            mcand  <= ACC_W'(job.bytes);
            mplier <= NS_PER_SEC;
            cnt    <= CNT_B;
            state  <= E_B_MUL;
          end
        end
        E_N_SUB: begin
          if (!alu_carry) begin
            delay <= '0;
            state <= E_DONE;
          end else begin
            nreg   <= alu_sum;
            acc    <= '0;
            mcand  <= ACC_W'(job.kbs);
            mplier <= MPL_W'(NS_PER_MS);
            cnt    <= CNT_R;
            state  <= E_D_MUL;
          end
        end
        E_OVF: begin
          if (alu_carry) begin
            delay <= DELAY_MAX;
            state <= E_DONE;
          end else begin
            acc   <= ACC_W'(nreg[ACC_W-1:DELAY_W]);
            quo   <= '0;
            cnt   <= CNT_Q;
            state <= E_DIV;
          end
        end
        E_DIV: begin
          acc <= alu_carry ? ACC_W'(alu_sum[D_W-1:0]) : ACC_W'(div_a[D_W-1:0]);
          quo <= {quo[DELAY_W-2:0], alu_carry};
          cnt <= cnt - 5'd1;
          if (cnt == '0) begin
            state <= E_INC;
          end
        end
        E_INC: begin
          delay <= alu_sum[DELAY_W] ? DELAY_MAX : alu_sum[DELAY_W-1:0];
          state <= E_DONE;
        end
        E_DONE: begin
          state <= E_IDLE;
        end
        default: begin
          state <= E_IDLE;
        end
      endcase
    end
  end

  assign res = '{busy: state != E_IDLE, valid: state == E_DONE, due: due, delay: delay};

  a_go_when_idle: assert property (@(posedge clk) disable iff (rst)
    job.go |-> state == E_IDLE)
    else $error("engine started while busy");

  a_rem_below_div: assert property (@(posedge clk) disable iff (rst)
    state == E_DIV |-> acc < ACC_W'(dreg))
    else $error("division remainder not below divisor");

  a_done_one_cycle: assert property (@(posedge clk) disable iff (rst)
    state == E_DONE |=> state == E_IDLE)
    else $error("engine result held for more than one cycle");

endmodule

[rtl/core/scheduled_bandwidth_throttle.sv]
// ----------------------------------------------------------------------------
// scheduled_bandwidth_throttle: interval rate limiter with hourly schedule
// Accumulates reported chunk bytes and, when a check is due, returns the
// number of 1 ms sleeps that brings the interval back under the limit.
//
//   channel | role   | handshake   | beat contents
//   --------+--------+-------------+----------------------------------------------
//   req     | sink   | valid/ready | operation, byte_count, now_ns, hour_slot,
//           |        |             | slot_rate
//   rsp     | source | valid/ready | delay_ms, check_done, grand_total
//   cfg     | sink   | valid/ready | checks_per_second (ready always high)
//
// One request at a time. A report that runs the check uses shift-add
// multiplies of 20, 30, 20 and 20 steps and a 32-step restoring division
// on one shared 96-bit adder.
// Reset (synchronous, active high) empties the schedule, clears counters and
// last check time, and loads checks_per_second with 1000.
// A stalled rsp holds its beat in the output register; req may still be
// accepted meanwhile, and the next result waits until the register frees.
// ----------------------------------------------------------------------------
module scheduled_bandwidth_throttle import sbt_pkg::*; #(
  parameter int SCHEDULE_SLOTS = 24
) (
  input logic      clk,
  input logic      rst,
  sbt_req_if.sink  req,
  sbt_rsp_if.source rsp,
  sbt_cfg_if.sink  cfg
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_LAUNCH = 3'd2;
  localparam logic [2:0] S_RUN    = 3'd3;
  localparam logic [2:0] S_SCALE  = 3'd4;
  localparam logic [2:0] S_STAMP  = 3'd5;
  localparam logic [2:0] S_FINISH = 3'd6;

  logic [2:0]         state;
  logic [CPS_W-1:0]   checks_per_second;
  logic [TOTAL_W-1:0] last_check_time;
  logic [TOTAL_W-1:0] interval_bytes;
  logic [TOTAL_W-1:0] total_bytes;

  // Per-request working registers
  logic [TIME_W-1:0]  now_q;
  logic [RATE_W-1:0]  kbs_q;
  logic [TIME_W-1:0]  elapsed_q;
  logic [DELAY_W-1:0] dly_q;
  logic               done_q;
  logic [MS_W-1:0]    ms_ns;

  // Output register
  logic               rsp_valid;
  logic [DELAY_W-1:0] rsp_delay;
  logic               rsp_done;
  logic [TOTAL_W-1:0] rsp_total;

  logic               in_fire;
  logic               out_load;
  logic [TOTAL_W:0]   diff;
  logic               ahead;
  logic [RATE_W-1:0]  sched_rate;
  sbt_job_t           eng_job;
  sbt_res_t           eng_res;

  assign req.ready = (state == S_IDLE);
  assign in_fire   = req.valid && req.ready;
  assign cfg.ready = 1'b1;

  // Load the output register once it is empty or being drained this cycle.
  assign out_load = (state == S_FINISH) && (!rsp_valid || rsp.ready);

  // Time advanced past the last check when now - last is positive.
  assign diff  = {2'b0, now_q} - {1'b0, last_check_time};
  assign ahead = !diff[TOTAL_W] && (diff[TOTAL_W-1:0] != '0);

  // The slot limit is looked up on the request beat and ready in S_CHECK.
  sbt_sched #(
    .SLOTS (SCHEDULE_SLOTS)
  ) u_sched (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (in_fire && req.operation == OP_WRITE),
    .wr_slot (req.hour_slot),
    .wr_rate (req.slot_rate),
    .rd_en   (in_fire),
    .rd_slot (req.hour_slot),
    .rd_rate (sched_rate)
  );

  assign eng_job = '{
    go:      state == S_LAUNCH,
    bytes:   interval_bytes,
    kbs:     kbs_q,
    elapsed: elapsed_q,
    cps:     checks_per_second
  };

  sbt_engine u_engine (
    .clk (clk),
    .rst (rst),
    .job (eng_job),
    .res (eng_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      checks_per_second <= CPS_RESET;
      last_check_time   <= '0;
      interval_bytes    <= '0;
      total_bytes       <= '0;
    end else begin
      if (cfg.valid) begin
        checks_per_second <= cfg.checks_per_second;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            dly_q  <= '0;
            done_q <= 1'b0;
            unique case (req.operation)
              OP_REPORT: begin
                // Count the chunk, then look at the schedule slot.
                interval_bytes <= interval_bytes + TOTAL_W'(req.byte_count);
                total_bytes    <= total_bytes + TOTAL_W'(req.byte_count);
                now_q          <= req.now_ns;
                state          <= S_CHECK;
              end
              OP_START: begin
                last_check_time <= {1'b0, req.now_ns};
                interval_bytes  <= '0;
                total_bytes     <= '0;
                state           <= S_FINISH;
              end
              default: begin
                // Slot write goes straight to the schedule; unused code is a no-op.
                state <= S_FINISH;
              end
            endcase
          end
        end
        S_CHECK: begin
          elapsed_q <= diff[TIME_W-1:0];
          kbs_q     <= sched_rate;
          // Unlimited slot or time not advanced: no check.
          if (sched_rate != '0 && ahead) begin
            state <= S_LAUNCH;
          end else begin
            state <= S_FINISH;
          end
        end
        S_LAUNCH: begin
          state <= S_RUN;
        end
        S_RUN: begin
          if (eng_res.valid) begin
            if (eng_res.due) begin
              dly_q          <= eng_res.delay;
              done_q         <= 1'b1;
              interval_bytes <= '0;
              state          <= S_SCALE;
            end else begin
              state <= S_FINISH;
            end
          end
        end
        S_SCALE: begin
          ms_ns <= {{(MS_W-DELAY_W){1'b0}}, dly_q} * {{(MS_W-20){1'b0}}, NS_PER_MS};
          state <= S_STAMP;
        end
        S_STAMP: begin
          // Restart the interval after the sleeps.
          last_check_time <= {1'b0, now_q} + TOTAL_W'(ms_ns);
          state           <= S_FINISH;
        end
        S_FINISH: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register: hold the beat until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp_delay <= dly_q;
      rsp_done  <= done_q;
      rsp_total <= total_bytes;
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.delay_ms    = rsp_delay;
  assign rsp.check_done  = rsp_done;
  assign rsp.grand_total = rsp_total;

  a_eng_result_in_run: assert property (@(posedge clk) disable iff (rst)
    eng_res.valid |-> state == S_RUN)
    else $error("engine result outside run state");

  a_eng_idle_with_top: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !eng_res.busy)
    else $error("engine busy while top level idle");

  a_stamp_not_behind: assert property (@(posedge clk) disable iff (rst)
    (out_load && done_q) |-> last_check_time >= {1'b0, now_q})
    else $error("check restarted interval before report time");

endmodule
